### rtl/bfd_pkg.sv
package bfd_pkg;

    // Three 9-bit channel sums, blue in slot 0, green in 1, red in 2.
    typedef logic [2:0][8:0] t_chan3;

    typedef enum logic {
        K_PASS,
        K_AVG
    } t_kind;

    // One classified request travelling from the front to the back.
    typedef struct packed {
        t_kind  kind;
        logic   last;
        t_chan3 sum;
        t_chan3 prev;
    } t_req;

    localparam logic [1:0] MODE_BIL2  = 2'd0;
    localparam logic [1:0] MODE_BIL4  = 2'd1;
    localparam logic [1:0] MODE_NEAR2 = 2'd2;
    localparam logic [1:0] MODE_NEAR4 = 2'd3;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH = 1'b1;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

endpackage

### rtl/bfd_in_if.sv
interface bfd_in_if;
    logic       valid;
    logic       ready;
    logic       frame_start;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
    logic [7:0] alpha_in;

    modport source (
        output valid, frame_start, blue_in, green_in, red_in, alpha_in,
        input  ready
    );

    modport sink (
        input  valid, frame_start, blue_in, green_in, red_in, alpha_in,
        output ready
    );
endinterface

### rtl/bfd_out_if.sv
interface bfd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;

    modport source (
        output valid, blue_out, green_out, red_out, row_end,
        input  ready
    );

    modport sink (
        input  valid, blue_out, green_out, red_out, row_end,
        output ready
    );
endinterface

### rtl/bfd_front.sv
module bfd_front #(
    parameter int MAX_OUT_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bfd_in_if.sink                         i_pix,
    input  logic [bfd_pkg::Q_CNT_W-1:0]    i_q_count,
    output logic                           o_push,
    output bfd_pkg::t_req                  o_req
);
    import bfd_pkg::*;

    localparam int CW = $clog2(4 * MAX_OUT_WIDTH + 1);
    localparam int AW = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;

    logic [1:0]            r_mode;
    logic [CFG_DATA_W-1:0] r_out_width;
    logic [CW-1:0]         r_col;
    logic [1:0]            r_phase;
    t_chan3                r_hsum;
    logic                  r_s1_valid;
    t_kind                 r_s1_kind;
    logic                  r_s1_last;
    t_chan3                r_s1_sum;
    t_chan3                r_rd_data;
    t_chan3                r_line_mem [MAX_OUT_WIDTH];

    logic [CW-1:0] n_col;
    logic [1:0]    n_phase;
    t_chan3        n_hsum;

    logic          f4;
    logic          nearest;
    logic [CW-1:0] w_eff;
    logic [CW-1:0] rowlen;
    logic [CW-1:0] col;
    logic [1:0]    phase;
    logic [1:0]    cp;
    logic [CW-1:0] oc_full;
    logic [AW-1:0] oc;
    logic [1:0]    lo;
    logic [1:0]    hi;
    logic [1:0]    sel;
    logic          in_row;
    logic          is_last;
    t_chan3        pix;
    t_chan3        sum_hi;
    logic [CW:0]   col_inc;
    logic          accept;
    logic          emit;
    t_kind         emit_kind;
    logic          do_store;
    logic          do_read;

    assign i_pix.ready = ((Q_CNT_W + 1)'(i_q_count) + (Q_CNT_W + 1)'(r_s1_valid))
                         < (Q_CNT_W + 1)'(Q_DEPTH);
    assign accept = i_pix.valid && i_pix.ready;

    // Geometry of the current mode
    always_comb begin
        f4      = (r_mode == MODE_BIL4) || (r_mode == MODE_NEAR4);
        nearest = (r_mode == MODE_NEAR2) || (r_mode == MODE_NEAR4);
        if (r_out_width == '0) begin
            w_eff = CW'(1);
        end else if (32'(r_out_width) > 32'(MAX_OUT_WIDTH)) begin
            w_eff = CW'(MAX_OUT_WIDTH);
        end else begin
            w_eff = CW'(r_out_width);
        end
        rowlen  = f4 ? (w_eff << 2) : (w_eff << 1);
        col     = i_pix.frame_start ? '0 : r_col;
        phase   = i_pix.frame_start ? 2'd0 : r_phase;
        cp      = f4 ? col[1:0] : {1'b0, col[0]};
        oc_full = f4 ? (col >> 2) : (col >> 1);
        oc      = oc_full[AW-1:0];
        lo      = f4 ? 2'd1 : 2'd0;
        hi      = lo + 2'd1;
        sel     = f4 ? 2'd2 : 2'd1;
        in_row  = col < rowlen;
        is_last = oc_full == (w_eff - CW'(1));
        pix[0]  = {1'b0, i_pix.blue_in};
        pix[1]  = {1'b0, i_pix.green_in};
        pix[2]  = {1'b0, i_pix.red_in};
        for (int c = 0; c < 3; c++) begin
            sum_hi[c] = r_hsum[c] + pix[c];
        end
        col_inc = {1'b0, col} + (CW + 1)'(1);
    end

    // Classify the accepted pixel and advance the position
    always_comb begin
        n_col     = r_col;
        n_phase   = r_phase;
        n_hsum    = r_hsum;
        emit      = 1'b0;
        emit_kind = K_PASS;
        do_store  = 1'b0;
        do_read   = 1'b0;
        if (accept) begin
            if (in_row) begin
                if (nearest) begin
                    if (phase == sel && cp == sel) begin
                        emit      = 1'b1;
                        emit_kind = K_PASS;
                    end
                end else if (cp == lo) begin
                    n_hsum = pix;
                end else if (cp == hi) begin
                    n_hsum = sum_hi;
                    if (phase == lo) begin
                        do_store = 1'b1;
                    end else if (phase == hi) begin
                        emit      = 1'b1;
                        emit_kind = K_AVG;
                        do_read   = 1'b1;
                    end
                end
            end
            if (col_inc >= {1'b0, rowlen}) begin
                n_col   = '0;
                n_phase = (phase + 2'd1) & (f4 ? 2'd3 : 2'd1);
            end else begin
                n_col   = col_inc[CW-1:0];
                n_phase = phase;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_BIL2;
            r_out_width <= CFG_DATA_W'(1);
            r_col       <= '0;
            r_phase     <= 2'd0;
            r_hsum      <= '0;
            r_s1_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MODE:      r_mode      <= i_cfg_data[1:0];
                    REG_OUT_WIDTH: r_out_width <= i_cfg_data;
                    default:       ;
                endcase
            end
            r_col      <= n_col;
            r_phase    <= n_phase;
            r_hsum     <= n_hsum;
            r_s1_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_s1_kind <= emit_kind;
            r_s1_last <= is_last;
            r_s1_sum  <= nearest ? pix : sum_hi;
        end
    end

    // Line buffer: pair sums of the upper averaged row per output column
    always_ff @(posedge i_clk) begin
        if (do_store) begin
            r_line_mem[oc] <= sum_hi;
        end
        if (do_read) begin
            r_rd_data <= r_line_mem[oc];
        end
    end

    assign o_push = r_s1_valid;
    always_comb begin
        o_req.kind = r_s1_kind;
        o_req.last = r_s1_last;
        o_req.sum  = r_s1_sum;
        o_req.prev = r_rd_data;
    end

    a_emit_staged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> r_s1_valid)
        else $error("front: emitted pixel did not reach the stage register");

    a_avg_bilinear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_kind == K_AVG) |-> $past(!nearest))
        else $error("front: average request issued in a nearest mode");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (i_q_count < Q_CNT_W'(Q_DEPTH)))
        else $error("front: staged request has no room in the queue");

endmodule

### rtl/bfd_queue.sv
module bfd_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  bfd_pkg::t_req               i_req,
    input  logic                        i_pop,
    output logic                        o_valid,
    output bfd_pkg::t_req               o_req,
    output logic [bfd_pkg::Q_CNT_W-1:0] o_count
);
    import bfd_pkg::*;

    t_req               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CNT_W'(1);
                2'b01:   r_count <= r_count - Q_CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    assign o_valid = r_count != '0;
    assign o_req   = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

### rtl/bfd_back.sv
module bfd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bfd_pkg::t_req i_req,
    output logic          o_pop,
    bfd_out_if.source     o_pix
);
    import bfd_pkg::*;

    logic                  r_valid;
    logic [2:0][7:0]       r_chan;
    logic                  r_last;
    logic [2:0][7:0]       res;
    logic [2:0][9:0]       avg_sum;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            avg_sum[c] = {1'b0, i_req.prev[c]} + {1'b0, i_req.sum[c]} + 10'd2;
            case (i_req.kind)
                K_AVG:   res[c] = avg_sum[c][9:2];
                K_PASS:  res[c] = i_req.sum[c][7:0];
                default: res[c] = i_req.sum[c][7:0];
            endcase
        end
    end

    // Refill the output register when empty or being drained
    assign o_pop = i_valid && (!r_valid || o_pix.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_chan <= res;
            r_last <= i_req.last;
        end
    end

    assign o_pix.valid     = r_valid;
    assign o_pix.blue_out  = r_chan[0];
    assign o_pix.green_out = r_chan[1];
    assign o_pix.red_out   = r_chan[2];
    assign o_pix.row_end   = r_last;

endmodule

### rtl/bgra_fixed_downscale_to_bgr.sv
// BGRA to BGR fixed-ratio downscaler. Source pixels enter one per clock in
// raster order on i_pix and BGR pixels leave on o_pix, alpha dropped; the
// sustained rate is one source pixel per clock, limited by the single line
// buffer access (one write or one read) each pixel needs. Input is held only
// when output stalls have filled the four-entry request queue together with
// the stage register. A result passes through the stage register and the
// request queue into the output register.
// Modes: bilinear 2x (average of each 2x2 block), bilinear 4x (average of the
// center 2x2 of each 4x4 block), nearest 2x (row 1, column 1) and nearest 4x
// (row 2, column 2); averages round as (sum + 2) >> 2. Set mode and out_width
// only while the block is idle. Assert frame_start on the first pixel of a
// frame. The line buffer is not cleared after reset: start each frame on the
// first row of a block and keep the geometry fixed within a frame.
module bgra_fixed_downscale_to_bgr #(
    parameter int MAX_OUT_WIDTH = 2048
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bfd_in_if.sink                         i_pix,
    bfd_out_if.source                      o_pix
);
    import bfd_pkg::*;

    // Front to queue: classified requests with their line buffer operand
    logic               q_push;
    t_req               q_in_req;
    // Queue to back
    logic               q_valid;
    t_req               q_head;
    logic               q_pop;
    // Fill level, used by the front to hold off input before the queue overflows
    logic [Q_CNT_W-1:0] q_count;

    // Track position, build pair sums, drive the line buffer
    bfd_front #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_pix       (i_pix),
        .i_q_count   (q_count),
        .o_push      (q_push),
        .o_req       (q_in_req)
    );

    // Decouple the front from output stalls
    bfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_req   (q_in_req),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_req   (q_head),
        .o_count (q_count)
    );

    // Round the average or pass the sample, hold it in the output register
    bfd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_req   (q_head),
        .o_pop   (q_pop),
        .o_pix   (o_pix)
    );

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
    import bfd_pkg::*;

    // Percent of cycles in which each side holds back on its own.
    localparam int IDLE_PCT     = 16;
    // Cycles to wait after the last result before a register write.
    localparam int DRAIN_CYCLES = 8;
    localparam int TAIL_CYCLES  = 24;
    // Cycles without any accepted request on either side before giving up.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1250;
    localparam int MAX_W        = 2048;
    // Output width of the steady run at the end.
    localparam int WIDE_W       = 64;
    localparam int PRINT_CAP    = 40;

    localparam logic [1:0] ALL_MODES [4] = '{MODE_BIL2, MODE_BIL4, MODE_NEAR2, MODE_NEAR4};

    // One source request as queued for the driver.
    typedef struct packed {
        logic       frame_start;
        logic [7:0] alpha;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } src_px_t;

    // One predicted output pixel.
    typedef struct packed {
        logic       row_end;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } bgr_px_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bfd_in_if  pix_in ();
    bfd_out_if pix_out ();

    bgra_fixed_downscale_to_bgr #(
        .MAX_OUT_WIDTH(MAX_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in),
        .o_pix      (pix_out)
    );

    always #4 i_clk = ~i_clk;

    // Pixels waiting for the driver, and output pixels waiting to be seen.
    src_px_t pixel_pending_q[$];
    bgr_px_t bgr_expected_q[$];

    int   mismatches;
    int   quiet_cycles;
    logic steady;   // suppress random idling on both sides

    // Shadow of the block: its registers and its scan position.
    logic [1:0]  cfg_mode;
    logic [11:0] cfg_width;
    logic [13:0] col_pos;
    logic [1:0]  row_ph;
    t_chan3      horiz_sum;
    t_chan3      line_sums [MAX_W];

    function automatic int eff_width(logic [11:0] w);
        if (w == 0) return 1;
        if (w > MAX_W) return MAX_W;
        return int'(w);
    endfunction

    // Advance the shadow by one source pixel and queue the output pixel it
    // completes, if any.
    function automatic void predict_downscale(src_px_t px);
        int               fac, w, rowlen, cp, oc, lo, hi, sel;
        logic             pointwise;
        logic [2:0][7:0]  chans;
        logic [2:0][7:0]  avg;
        t_chan3           sum_now;
        fac       = (cfg_mode == MODE_BIL4 || cfg_mode == MODE_NEAR4) ? 4 : 2;
        pointwise = (cfg_mode == MODE_NEAR2 || cfg_mode == MODE_NEAR4);
        w         = eff_width(cfg_width);
        rowlen    = fac * w;
        chans     = {px.red, px.green, px.blue};
        if (px.frame_start) begin
            col_pos = '0;
            row_ph  = '0;
        end
        cp  = int'(col_pos) % fac;
        oc  = int'(col_pos) / fac;
        lo  = (fac == 4) ? 1 : 0;
        hi  = lo + 1;
        sel = (fac == 4) ? 2 : 1;

        // A column past the row length (geometry shrunk mid-row) yields nothing.
        if (int'(col_pos) < rowlen) begin
            if (pointwise) begin
                if (row_ph == sel && cp == sel) begin
                    bgr_expected_q.push_back('{row_end: (oc == w - 1), red: px.red,
                                               green: px.green, blue: px.blue});
                end
            end else if (cp == lo) begin
                for (int c = 0; c < 3; c++) horiz_sum[c] = {1'b0, chans[c]};
            end else if (cp == hi) begin
                for (int c = 0; c < 3; c++) sum_now[c] = horiz_sum[c] + 9'(chans[c]);
                horiz_sum = sum_now;
                if (row_ph == lo) begin
                    line_sums[oc] = sum_now;
                end else if (row_ph == hi) begin
                    // Round to nearest: add half of four before dropping two bits.
                    for (int c = 0; c < 3; c++) begin
                        avg[c] = 8'((11'(line_sums[oc][c]) + 11'(sum_now[c]) + 11'd2) >> 2);
                    end
                    bgr_expected_q.push_back('{row_end: (oc == w - 1), red: avg[2],
                                               green: avg[1], blue: avg[0]});
                end
            end
        end

        col_pos = col_pos + 14'd1;
        if (int'(col_pos) >= rowlen) begin
            col_pos = '0;
            row_ph  = 2'((int'(row_ph) + 1) & (fac - 1));
        end
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < PRINT_CAP) $display("%0t ERROR %s", $time, msg);
        mismatches++;
    endtask

    // Driver: present queued pixels, hold a request until it is taken, and
    // feed every accepted request to the predictor.
    always @(posedge i_clk) begin : drive_pixels
        src_px_t nxt;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else begin
            if (pix_in.valid && pix_in.ready) begin
                predict_downscale('{frame_start: pix_in.frame_start, alpha: pix_in.alpha_in,
                                    red: pix_in.red_in, green: pix_in.green_in,
                                    blue: pix_in.blue_in});
            end
            if (!pix_in.valid || pix_in.ready) begin
                if (pixel_pending_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    nxt                = pixel_pending_q.pop_front();
                    pix_in.valid       <= 1'b1;
                    pix_in.frame_start <= nxt.frame_start;
                    pix_in.blue_in     <= nxt.blue;
                    pix_in.green_in    <= nxt.green;
                    pix_in.red_in      <= nxt.red;
                    pix_in.alpha_in    <= nxt.alpha;
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and compare each output pixel with the oldest
    // prediction.
    always @(posedge i_clk) begin : check_pixels
        bgr_px_t want;
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                if (bgr_expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected pixel b=%0d g=%0d r=%0d end=%0b",
                                              pix_out.blue_out, pix_out.green_out,
                                              pix_out.red_out, pix_out.row_end));
                end else begin
                    want = bgr_expected_q.pop_front();
                    if (pix_out.blue_out !== want.blue)
                        report_mismatch($sformatf("blue got %0d want %0d",
                                                  pix_out.blue_out, want.blue));
                    if (pix_out.green_out !== want.green)
                        report_mismatch($sformatf("green got %0d want %0d",
                                                  pix_out.green_out, want.green));
                    if (pix_out.red_out !== want.red)
                        report_mismatch($sformatf("red got %0d want %0d",
                                                  pix_out.red_out, want.red));
                    if (pix_out.row_end !== want.row_end)
                        report_mismatch($sformatf("row_end got %0b want %0b",
                                                  pix_out.row_end, want.row_end));
                end
            end
            pix_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Check at the falling edge so every update of the rising edge has landed.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (!(pixel_pending_q.size() == 0 && !pix_in.valid && bgr_expected_q.size() == 0));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_MODE) cfg_mode = data[1:0];
        else cfg_width = data;
    endtask

    // Let the block go idle, then set both registers. Junk goes in the unused
    // bits of the mode word.
    task automatic set_geometry(logic [1:0] m, logic [11:0] w);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        write_reg(REG_MODE, {10'($urandom), m});
        write_reg(REG_OUT_WIDTH, w);
    endtask

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Queue a raster run of random pixels. With noise on, drop in a stray
    // frame start now and then and restart frames at random on boundaries.
    task automatic queue_stream(int count, int frame_len, bit open_frame, bit noisy);
        int      pos;
        src_px_t px;
        pos = 0;
        for (int k = 0; k < count; k++) begin
            px.alpha = 8'($urandom);
            px.blue  = rand_chan();
            px.green = rand_chan();
            px.red   = rand_chan();
            if (k == 0) px.frame_start = open_frame;
            else if (noisy && $urandom_range(255) == 0) px.frame_start = 1'b1;
            else if (noisy && pos == frame_len) px.frame_start = 1'($urandom_range(1));
            else px.frame_start = 1'b0;
            if (px.frame_start || pos == frame_len) pos = 0;
            pos++;
            pixel_pending_q.push_back(px);
        end
    endtask

    initial begin
        int         random_items;
        int         phase_no;
        int         fac;
        int         frame_len;
        int         count;
        int         half;
        logic [1:0] m;
        logic [11:0] w;

        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_in.valid       = 1'b0;
        pix_in.frame_start = 1'b0;
        pix_in.blue_in     = '0;
        pix_in.green_in    = '0;
        pix_in.red_in      = '0;
        pix_in.alpha_in    = '0;
        pix_out.ready      = 1'b0;
        steady             = 1'b0;
        mismatches         = 0;
        quiet_cycles       = 0;
        cfg_mode           = MODE_BIL2;
        cfg_width          = 12'd1;
        col_pos            = '0;
        row_ph             = '0;
        horiz_sum          = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Bilinear 2x, width 0 behaves as one column. First block saturates
        // every channel; second checks rounding on tiny sums.
        set_geometry(MODE_BIL2, 12'd0);
        pixel_pending_q.push_back('{frame_start: 1, alpha: 8'hFF, red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        pixel_pending_q.push_back('{frame_start: 0, alpha: 8'h00, red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        pixel_pending_q.push_back('{frame_start: 0, alpha: 8'hFF, red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        pixel_pending_q.push_back('{frame_start: 0, alpha: 8'h00, red: 8'hFF, green: 8'hFF, blue: 8'hFF});
        pixel_pending_q.push_back('{frame_start: 0, alpha: 8'h5A, red: 8'd2, green: 8'd1, blue: 8'd0});
        pixel_pending_q.push_back('{frame_start: 0, alpha: 8'hA5, red: 8'd2, green: 8'd1, blue: 8'd0});
        pixel_pending_q.push_back('{frame_start: 0, alpha: 8'h00, red: 8'd1, green: 8'd0, blue: 8'd0});
        pixel_pending_q.push_back('{frame_start: 0, alpha: 8'hFF, red: 8'd0, green: 8'd0, blue: 8'd1});

        // Shrink the row while parked mid-row in nearest 2x: the next pixel
        // lies beyond the new row length, yields nothing, and wraps to the
        // next row phase where two sampled pixels follow.
        set_geometry(MODE_NEAR2, 12'd8);
        queue_stream(12, 0, 1'b1, 1'b0);
        set_geometry(MODE_NEAR2, 12'd2);
        queue_stream(5, 0, 1'b0, 1'b0);

        // Random phases: first one per mode, then random modes and widths.
        random_items = 0;
        phase_no     = 0;
        while (random_items < RANDOM_ITEMS) begin
            m = ALL_MODES[(phase_no < 4) ? phase_no : $urandom_range(3)];
            case ($urandom_range(19))
                0:       w = 12'd0;
                1, 2:    w = 12'($urandom_range(7, 24));
                default: w = 12'($urandom_range(1, 6));
            endcase
            fac       = (m == MODE_BIL4 || m == MODE_NEAR4) ? 4 : 2;
            frame_len = fac * fac * eff_width(w);
            count     = frame_len * $urandom_range(1, 2) + $urandom_range(0, 2 * fac * eff_width(w));
            set_geometry(m, w);
            // Now and then hold the sender until every pending result is out.
            if (phase_no == 1 || $urandom_range(3) == 0) begin
                half = count / 2;
                queue_stream(half, frame_len, 1'b1, 1'b1);
                wait_drained();
                queue_stream(count - half, frame_len, 1'b0, 1'b1);
            end else begin
                queue_stream(count, frame_len, 1'b1, 1'b1);
            end
            random_items += count;
            phase_no++;
        end

        // A wider row: one full 2x frame with no idling on either side.
        set_geometry(MODE_BIL2, 12'(WIDE_W));
        steady <= 1'b1;
        queue_stream(4 * WIDE_W, 4 * WIDE_W, 1'b1, 1'b0);
        wait_drained();
        steady <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && bgr_expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
